// ----- design/tfcm_pkg.sv -----
// Shared constants and types for the thermal false colour map unit.
`default_nettype none

package tfcm_pkg;

    localparam int TEMP_W     = 16;
    localparam int DIFF_W     = TEMP_W + 1;
    localparam int NUM_W      = 24;
    localparam int IDX_W      = 8;
    localparam int COL_W      = 8;
    localparam int RGB_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int NORM_SCALE = 180;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = IDX_W / DIV_STEPS;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(NORM_SCALE);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MAX = 2'd1;

    localparam logic [TEMP_W-1:0] FRAME_MIN_RST = 16'd0;
    localparam logic [TEMP_W-1:0] FRAME_MAX_RST = 16'd2560;

    localparam int LATENCY = 2 + 1 + DIV_STAGES + 2;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [TEMP_W-1:0] den;
        logic [NUM_W-1:0]  den_lim;
        logic              zero;
    } t_norm;

endpackage

`default_nettype wire

// ----- design/thermal_false_colour_map_unit.sv -----
// Top level of the thermal false colour map unit: registers and pipeline.
`default_nettype none

// Maps one pixel temperature per clock to an ironbow palette colour. An item
// is taken whenever start is high; busy never rises. Each result appears on
// the o_ ports for one cycle with o_valid once its item has passed through:
// two offset and scale stages, a range compare, four stages of an
// 8-bit restoring divider at two quotient bits per stage, and two palette
// stages. Results cannot be held off by the receiver. Write frame_min_temp and
// frame_max_temp only while no item is in flight.
module thermal_false_colour_map_unit
    import tfcm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [TEMP_W-1:0]    i_pixel_temp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TEMP_W-1:0]    i_cfg_wdata,
    output logic                      o_valid,
    output logic [IDX_W-1:0]          o_palette_index,
    output logic [COL_W-1:0]          o_red,
    output logic [COL_W-1:0]          o_green,
    output logic [COL_W-1:0]          o_blue,
    output logic [RGB_W-1:0]          o_pixel_rgb565
);

    logic [TEMP_W-1:0] r_frame_min_temp;
    logic [TEMP_W-1:0] r_frame_max_temp;
    logic              norm_valid;
    t_norm             norm_data;
    logic              div_valid;
    logic [IDX_W-1:0]  div_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_min_temp <= FRAME_MIN_RST;
            r_frame_max_temp <= FRAME_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_MIN: r_frame_min_temp <= i_cfg_wdata;
                CFG_FRAME_MAX: r_frame_max_temp <= i_cfg_wdata;
                default:       r_frame_min_temp <= r_frame_min_temp;
            endcase
        end
    end

    assign busy = 1'b0;

    tfcm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_temp  (i_pixel_temp),
        .i_min   (r_frame_min_temp),
        .i_max   (r_frame_max_temp),
        .o_valid (norm_valid),
        .o_norm  (norm_data)
    );

    tfcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_valid),
        .i_norm  (norm_data),
        .o_valid (div_valid),
        .o_index (div_index)
    );

    tfcm_palette u_palette (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .i_index  (div_index),
        .o_valid  (o_valid),
        .o_index  (o_palette_index),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue),
        .o_rgb565 (o_pixel_rgb565)
    );

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("item lost in pipeline");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without item");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_palette_index <= IDX_MAX))
        else $error("palette index above top");

    a_bottom_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_palette_index == '0)) |->
            ((o_red == '0) && (o_green == '0) && (o_blue == 8'd20)))
        else $error("bottom colour mismatch");
`endif

endmodule

`default_nettype wire

// ----- design/tfcm_norm.sv -----
// Offset and scale stages: temperature difference, range and scaled numerator.
`default_nettype none

module tfcm_norm
    import tfcm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [TEMP_W-1:0] i_temp,
    input  wire logic [TEMP_W-1:0] i_min,
    input  wire logic [TEMP_W-1:0] i_max,
    output logic                   o_valid,
    output t_norm                  o_norm
);

    logic              r_v0;
    logic [DIFF_W-1:0] r_dt;
    logic [DIFF_W-1:0] r_den;
    logic [DIFF_W-1:0] n_dt;
    logic [DIFF_W-1:0] n_den;
    t_norm             r_norm;
    t_norm             n_norm;
    logic              r_v1;

    always_comb begin
        n_dt  = {i_temp[TEMP_W-1], i_temp} - {i_min[TEMP_W-1], i_min};
        n_den = {i_max[TEMP_W-1], i_max} - {i_min[TEMP_W-1], i_min};
    end

    always_comb begin
        n_norm.num     = NUM_W'(r_dt[TEMP_W-1:0]) * NUM_W'(NORM_SCALE);
        n_norm.den     = r_den[TEMP_W-1:0];
        n_norm.den_lim = NUM_W'(r_den[TEMP_W-1:0]) * NUM_W'(NORM_SCALE + 1);
        n_norm.zero    = r_dt[DIFF_W-1] | r_den[DIFF_W-1] | (r_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
        r_dt   <= n_dt;
        r_den  <= n_den;
        r_norm <= n_norm;
    end

    assign o_valid = r_v1;
    assign o_norm  = r_norm;

endmodule

`default_nettype wire

// ----- design/tfcm_div.sv -----
// Pipelined restoring divider with clamp, giving the palette index.
`default_nettype none

module tfcm_div
    import tfcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  t_norm                 i_norm,
    output logic                  o_valid,
    output logic [IDX_W-1:0]      o_index
);

    logic [DIV_STAGES:0]       r_v;
    logic [DIV_STAGES:0]       r_zero;
    logic [DIV_STAGES:0]       r_over;
    logic [IDX_W-1:0]          r_q   [DIV_STAGES+1];
    logic [NUM_W-1:0]          r_rem [DIV_STAGES];
    logic [TEMP_W-1:0]         r_den [DIV_STAGES];
    logic [NUM_W-1:0]          n_rem [DIV_STAGES];
    logic [IDX_W-1:0]          n_q   [DIV_STAGES];

    always_comb begin
        logic [NUM_W-1:0] rem;
        logic [NUM_W-1:0] trial;
        logic [IDX_W-1:0] q;
        int               b;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = r_rem[s];
            q   = r_q[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                b     = IDX_W - 1 - s * DIV_STEPS - k;
                trial = NUM_W'(r_den[s]) << b;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    q[b] = 1'b1;
                end
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DIV_STAGES-1:0], i_valid};
        end
        r_rem[0]  <= i_norm.num;
        r_den[0]  <= i_norm.den;
        r_q[0]    <= '0;
        r_zero[0] <= i_norm.zero;
        r_over[0] <= i_norm.num >= i_norm.den_lim;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_q[s+1]    <= n_q[s];
            r_zero[s+1] <= r_zero[s];
            r_over[s+1] <= r_over[s];
        end
        for (int s = 0; s < DIV_STAGES - 1; s++) begin
            r_rem[s+1] <= n_rem[s];
            r_den[s+1] <= r_den[s];
        end
    end

    assign o_valid = r_v[DIV_STAGES];
    assign o_index = r_zero[DIV_STAGES] ? '0 :
                     r_over[DIV_STAGES] ? IDX_MAX : r_q[DIV_STAGES];

endmodule

`default_nettype wire

// ----- design/tfcm_palette.sv -----
// Palette stages: segment select, then per-channel colour and RGB565 packing.
`default_nettype none

module tfcm_palette
    import tfcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [IDX_W-1:0] i_index,
    output logic                  o_valid,
    output logic [IDX_W-1:0]      o_index,
    output logic [COL_W-1:0]      o_red,
    output logic [COL_W-1:0]      o_green,
    output logic [COL_W-1:0]      o_blue,
    output logic [RGB_W-1:0]      o_rgb565
);

    typedef enum logic [2:0] {
        SEG_BLUE,
        SEG_PURPLE,
        SEG_MAGENTA,
        SEG_ORANGE,
        SEG_YELLOW,
        SEG_WHITE
    } t_seg;

    logic             r_v0;
    logic [IDX_W-1:0] r_j0;
    t_seg             r_seg;
    logic [4:0]       r_d;
    t_seg             n_seg;
    logic [IDX_W-1:0] n_base;

    logic             r_v1;
    logic [IDX_W-1:0] r_j1;
    logic [COL_W-1:0] r_r;
    logic [COL_W-1:0] r_g;
    logic [COL_W-1:0] r_b;
    logic [COL_W-1:0] n_r;
    logic [COL_W-1:0] n_g;
    logic [COL_W-1:0] n_b;

    always_comb begin
        if (i_index < 8'd30) begin
            n_seg  = SEG_BLUE;
            n_base = 8'd0;
        end else if (i_index < 8'd60) begin
            n_seg  = SEG_PURPLE;
            n_base = 8'd30;
        end else if (i_index < 8'd90) begin
            n_seg  = SEG_MAGENTA;
            n_base = 8'd60;
        end else if (i_index < 8'd120) begin
            n_seg  = SEG_ORANGE;
            n_base = 8'd90;
        end else if (i_index < 8'd150) begin
            n_seg  = SEG_YELLOW;
            n_base = 8'd120;
        end else begin
            n_seg  = SEG_WHITE;
            n_base = 8'd150;
        end
    end

    always_comb begin
        logic [15:0] d16;
        logic [15:0] b_mag;
        logic [15:0] b_org;
        logic [19:0] g_yel;
        logic [15:0] g_wht;
        d16   = 16'(r_d);
        b_mag = ((16'd240 - d16 * 16'd7) * 16'd171) >> 9;
        b_org = ((16'd30 - d16) * 16'd171) >> 9;
        g_yel = (20'(d16 * 16'd35) * 20'd683) >> 12;
        g_wht = ((d16 * 16'd2) * 16'd171) >> 9;
        n_r = '0;
        n_g = '0;
        n_b = '0;
        case (r_seg)
            SEG_BLUE: begin
                n_b = COL_W'(16'd20 + d16 * 16'd4);
            end
            SEG_PURPLE: begin
                n_r = COL_W'(d16 * 16'd4);
                n_b = COL_W'(16'd140 - d16 * 16'd2);
            end
            SEG_MAGENTA: begin
                n_r = COL_W'(16'd120 + ((d16 * 16'd9) >> 1));
                n_b = COL_W'(b_mag);
            end
            SEG_ORANGE: begin
                n_r = 8'd255;
                n_g = COL_W'(d16 * 16'd2);
                n_b = COL_W'(b_org);
            end
            SEG_YELLOW: begin
                n_r = 8'd255;
                n_g = COL_W'(20'd60 + g_yel);
            end
            SEG_WHITE: begin
                n_r = 8'd255;
                n_g = COL_W'(16'd235 + g_wht);
                n_b = COL_W'((d16 * 16'd17) >> 1);
            end
            default: begin
                n_r = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
        r_j0  <= i_index;
        r_seg <= n_seg;
        r_d   <= 5'(i_index - n_base);
        r_j1  <= r_j0;
        r_r   <= n_r;
        r_g   <= n_g;
        r_b   <= n_b;
    end

    assign o_valid  = r_v1;
    assign o_index  = r_j1;
    assign o_red    = r_r;
    assign o_green  = r_g;
    assign o_blue   = r_b;
    assign o_rgb565 = {r_r[7:3], r_g[7:2], r_b[7:3]};

endmodule

`default_nettype wire
